// ===== sv/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

    // command codes on the cmd field
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_BUSY  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_RESET_LOW    = 3'd0;
    localparam logic [2:0] REG_PRESENCE     = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL   = 3'd2;
    localparam logic [2:0] REG_WRITE_ZERO   = 3'd3;
    localparam logic [2:0] REG_WRITE_ONE    = 3'd4;
    localparam logic [2:0] REG_RECOVERY     = 3'd5;
    localparam logic [2:0] REG_READ_LOW     = 3'd6;
    localparam logic [2:0] REG_READ_SAMPLE  = 3'd7;

    // ticks a read slot stays released after its sample point
    localparam logic [10:0] READ_HOLD_TICKS = 11'd50;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] presence_wait;
        logic [9:0] reset_tail;
        logic [7:0] write_zero_low;
        logic [7:0] write_one_low;
        logic [7:0] recovery;
        logic [7:0] read_low;
        logic [7:0] read_sample;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       done_res;
        logic [7:0] read_value;
        logic       active;
        logic       rejected;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/owm_cfg.sv =====
`default_nettype none

module owm_cfg (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  wire        [2:0] wr_index,
    input  wire        [9:0] wr_data,
    output owm_pkg::cfg_t    cfg
);

    owm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low      <= 10'd480;
            cfg_reg.presence_wait  <= 8'd80;
            cfg_reg.reset_tail     <= 10'd400;
            cfg_reg.write_zero_low <= 8'd60;
            cfg_reg.write_one_low  <= 8'd10;
            cfg_reg.recovery       <= 8'd2;
            cfg_reg.read_low       <= 8'd2;
            cfg_reg.read_sample    <= 8'd10;
        end
        else if (wr_en)
        begin
            case (wr_index)
                owm_pkg::REG_RESET_LOW:   cfg_reg.reset_low      <= wr_data;
                owm_pkg::REG_PRESENCE:    cfg_reg.presence_wait  <= wr_data[7:0];
                owm_pkg::REG_RESET_TAIL:  cfg_reg.reset_tail     <= wr_data;
                owm_pkg::REG_WRITE_ZERO:  cfg_reg.write_zero_low <= wr_data[7:0];
                owm_pkg::REG_WRITE_ONE:   cfg_reg.write_one_low  <= wr_data[7:0];
                owm_pkg::REG_RECOVERY:    cfg_reg.recovery       <= wr_data[7:0];
                owm_pkg::REG_READ_LOW:    cfg_reg.read_low       <= wr_data[7:0];
                owm_pkg::REG_READ_SAMPLE: cfg_reg.read_sample    <= wr_data[7:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/owm_core.sv =====
`default_nettype none

module owm_core (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              step,
    input  wire        [2:0] cmd,
    input  wire        [7:0] data_byte,
    input  wire              line_level,
    input  owm_pkg::cfg_t    cfg,
    output owm_pkg::res_t    res
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RST_MAIN = 2'd1;
    localparam logic [1:0] PH_RST_TAIL = 2'd2;
    localparam logic [1:0] PH_SLOT     = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  op_reg, op_next;
    logic [10:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bit_reg, bit_next;
    logic        samp_reg, samp_next;

    logic        is_cmd;
    logic [10:0] rst_sp;
    logic [11:0] pos_inc;
    logic [7:0]  slot_low;
    logic [10:0] slot_len;
    logic [8:0]  read_sp;
    logic        slot_end;
    logic [3:0]  bit_inc;

    always_comb
    begin
        is_cmd     = (cmd == owm_pkg::CMD_RESET) || (cmd == owm_pkg::CMD_WRITE) ||
                     (cmd == owm_pkg::CMD_READ) || (cmd == owm_pkg::CMD_BUSY);
        phase_next = phase_reg;
        op_next    = op_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        samp_next  = samp_reg;
        res        = '0;
        rst_sp     = {1'b0, cfg.reset_low} + {3'b000, cfg.presence_wait};
        read_sp    = {1'b0, cfg.read_low} + {1'b0, cfg.read_sample};
        slot_low   = '0;
        slot_len   = '0;
        slot_end   = 1'b0;
        bit_inc    = '0;

        // command start: the accepting tick is already its first tick
        if (phase_reg == PH_IDLE)
        begin
            if (is_cmd)
            begin
                op_next    = cmd;
                tick_next  = '0;
                bit_next   = '0;
                samp_next  = 1'b0;
                shift_next = (cmd == owm_pkg::CMD_WRITE) ? data_byte : 8'd0;
                phase_next = (cmd == owm_pkg::CMD_RESET) ? PH_RST_MAIN : PH_SLOT;
            end
        end
        else if (is_cmd)
        begin
            res.rejected = 1'b1;
        end

        pos_inc = {1'b0, tick_next} + 12'd1;

        case (phase_next)
            PH_RST_MAIN:
            begin
                res.active    = 1'b1;
                res.drive_low = (tick_next < {1'b0, cfg.reset_low});
                if (tick_next >= rst_sp)
                begin
                    samp_next = ~line_level;
                    if (cfg.reset_tail == 10'd0)
                    begin
                        res.done_res   = 1'b1;
                        res.read_value = {7'd0, samp_next};
                        phase_next     = PH_IDLE;
                        op_next        = owm_pkg::CMD_TICK;
                        tick_next      = '0;
                        bit_next       = '0;
                    end
                    else
                    begin
                        phase_next = PH_RST_TAIL;
                        tick_next  = '0;
                    end
                end
                else
                begin
                    tick_next = pos_inc[10:0];
                end
            end
            PH_RST_TAIL:
            begin
                res.active = 1'b1;
                if (pos_inc >= {2'b00, cfg.reset_tail})
                begin
                    res.done_res   = 1'b1;
                    res.read_value = {7'd0, samp_next};
                    phase_next     = PH_IDLE;
                    op_next        = owm_pkg::CMD_TICK;
                    tick_next      = '0;
                    bit_next       = '0;
                end
                else
                begin
                    tick_next = pos_inc[10:0];
                end
            end
            PH_SLOT:
            begin
                res.active = 1'b1;
                if (op_next == owm_pkg::CMD_WRITE)
                begin
                    slot_low = cfg.write_zero_low;
                    if (shift_next[0] && (cfg.write_one_low < cfg.write_zero_low))
                    begin
                        slot_low = cfg.write_one_low;
                    end
                    slot_len = {3'b000, cfg.write_zero_low} + {3'b000, cfg.recovery};
                    if (slot_len == 11'd0)
                    begin
                        slot_len = 11'd1;
                    end
                end
                else
                begin
                    slot_low = cfg.read_low;
                    slot_len = {2'b00, read_sp} + owm_pkg::READ_HOLD_TICKS
                               + {3'b000, cfg.recovery} + 11'd1;
                    if (tick_next == {2'b00, read_sp})
                    begin
                        if (op_next == owm_pkg::CMD_BUSY)
                        begin
                            samp_next = ~line_level;
                        end
                        else if (line_level)
                        begin
                            shift_next[bit_next[2:0]] = 1'b1;
                        end
                    end
                end
                res.drive_low = (tick_next < {3'b000, slot_low});
                slot_end      = (pos_inc >= {1'b0, slot_len});
                if (slot_end)
                begin
                    if (op_next == owm_pkg::CMD_WRITE)
                    begin
                        shift_next = {1'b0, shift_next[7:1]};
                    end
                    bit_inc  = bit_next + 4'd1;
                    bit_next = bit_inc;
                    if ((op_next == owm_pkg::CMD_BUSY) || (bit_inc >= 4'd8))
                    begin
                        res.done_res = 1'b1;
                        if (op_next == owm_pkg::CMD_BUSY)
                        begin
                            res.read_value = {7'd0, samp_next};
                        end
                        else if (op_next == owm_pkg::CMD_READ)
                        begin
                            res.read_value = shift_next;
                        end
                        phase_next = PH_IDLE;
                        op_next    = owm_pkg::CMD_TICK;
                        tick_next  = '0;
                        bit_next   = '0;
                    end
                    else
                    begin
                        tick_next = '0;
                    end
                end
                else
                begin
                    tick_next = pos_inc[10:0];
                end
            end
            default:
            begin
                res.active = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= owm_pkg::CMD_TICK;
            tick_reg  <= '0;
            shift_reg <= '0;
            bit_reg   <= '0;
            samp_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            samp_reg  <= samp_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master.sv =====
// One-wire bus master driven by one request per 1 us tick. Each accepted
// request is one tick: cmd 0 just advances time, cmd 1..4 starts a reset /
// presence check, byte write, byte read or busy poll when idle (the accepting
// tick is the first tick of that operation), and is rejected and flagged when
// an operation is already running. Every request yields exactly one response
// carrying drive_low for that tick, active, rejected, and on the final tick
// done_res with read_value (read byte, presence bit or busy bit; 0 for a
// write). Codes 5..7 count as plain ticks. Throughput is one request per clock
// while out_ready drains the response: the tick counter compare, slot timing
// and shift are all combinational between the state registers and the
// response register, which is refilled in the same cycle it is drained. The
// response is valid the cycle after acceptance. Timing registers (index 0..7:
// reset low, presence wait, reset tail, write-zero low, write-one low,
// recovery, read low, read sample) are written through the cfg channel, which
// is always ready; write them only while the bus master is idle.
`default_nettype none

module one_wire_bus_master (
    input  wire        clk,
    input  wire        rst_n,
    // request channel
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [2:0] cmd,
    input  wire  [7:0] data_byte,
    input  wire        line_level,
    // response channel
    output logic       out_valid,
    input  wire        out_ready,
    output logic       drive_low,
    output logic       done_res,
    output logic [7:0] read_value,
    output logic       active,
    output logic       rejected,
    // configuration channel
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [2:0] cfg_index,
    input  wire  [9:0] cfg_data
);

    owm_pkg::cfg_t cfg;
    owm_pkg::res_t res;
    owm_pkg::res_t res_reg;
    logic          out_valid_reg;
    logic          step;

    // take a request whenever the response slot is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    owm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .line_level (line_level),
        .cfg        (cfg),
        .res        (res)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive_low  = res_reg.drive_low;
    assign done_res   = res_reg.done_res;
    assign read_value = res_reg.read_value;
    assign active     = res_reg.active;
    assign rejected   = res_reg.rejected;

endmodule

`default_nettype wire
